>>> rtl/ard_pkg.sv
// shared types and codes for the address region decoder
`timescale 1ns / 1ps

package ard_pkg;

    // default configuration
    localparam int REGION_SLOTS_DEF = 8;
    localparam int ADDRESS_BITS_DEF = 32;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_MISS       = 3'd1,
        ST_ADDED      = 3'd2,
        ST_ZERO       = 3'd3,
        ST_OVERLAP    = 3'd4,
        ST_FULL       = 3'd5,
        ST_MISALIGNED = 3'd6
    } status_t;

    // control flags of the token that walks the cell chain
    typedef struct packed {
        logic active;     // token present at this point of the chain
        logic add;        // add transfer, else lookup
        logic settled;    // result fixed at entry (zero size or misaligned)
        logic overlap;    // add met a stored region
        logic free_found; // add found a free slot
        logic hit;        // lookup found its region
        logic hit_kind;   // kind of the region found
    } tok_ctrl_t;

endpackage

>>> rtl/address_region_decoder.sv
// top level of the address region decoder: entry stage, cell chain and result stage
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; busy then stays high
// while the command walks the chain of REGION_SLOTS cells, one cell per cycle,
// and the single result appears with done high for one cycle once it has passed
// the entry stage, the cell chain and the result stage. A new command may be
// given in the cycle that done is high. The result cannot be held
// off: capture it while done is high.
// An add writes its slot at the same edge that the result is registered.

module address_region_decoder
    import ard_pkg::*;
#(
    parameter int REGION_SLOTS = REGION_SLOTS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] address,
    input  logic [3:0]  access_bytes,
    input  logic [31:0] region_size,
    input  logic        region_kind,
    input  logic [7:0]  region_tag,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  found_tag,
    output logic        found_kind,
    output logic [31:0] offset
);

    localparam int AW = ADDRESS_BITS;
    localparam int N  = REGION_SLOTS;
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    // chain links: index 0 is the entry stage, index N the last cell
    tok_ctrl_t       ch_ctrl [0:N];
    logic [AW-1:0]   ch_addr [0:N];
    logic [AW:0]     ch_lim  [0:N];
    logic [7:0]      ch_tag  [0:N];
    logic [31:0]     ch_off  [0:N];
    logic [IW-1:0]   ch_idx  [0:N];

    logic            accept;
    logic [AW-1:0]   addr_in;
    logic [AW-1:0]   size_in;
    logic            size_ok;
    logic            align_ok;

    logic            busy_reg, busy_next;
    tok_ctrl_t       entry_ctrl_reg, entry_ctrl_next;
    logic [AW-1:0]   entry_addr_reg;
    logic [AW:0]     entry_lim_reg, entry_lim_next;
    logic            item_kind_reg;
    logic [7:0]      item_tag_reg;

    logic            done_reg, done_next;
    status_t         status_reg, status_next;
    logic [7:0]      ftag_reg, ftag_next;
    logic            fkind_reg, fkind_next;
    logic [31:0]     off_reg, off_next;

    logic            wr_en;
    tok_ctrl_t       last;

    assign accept  = start && !busy_reg;
    assign addr_in = AW'(address);
    assign size_in = AW'(region_size);

    // access size and alignment check
    always_comb
    begin
        size_ok = 1'b0;
        case (access_bytes)
            4'd1, 4'd2, 4'd4, 4'd8: size_ok = 1'b1;
            default:                size_ok = 1'b0;
        endcase
        align_ok = size_ok && ((addr_in[3:0] & (access_bytes - 4'd1)) == 4'd0);
    end

    // entry stage: decode the command into a token
    always_comb
    begin
        entry_ctrl_next        = '0;
        entry_ctrl_next.active = accept;
        entry_ctrl_next.add    = (command == CMD_ADD);
        if (command == CMD_ADD)
        begin
            entry_ctrl_next.settled = (size_in == '0);
            entry_lim_next          = {1'b0, addr_in} + {1'b0, size_in};
        end
        else
        begin
            entry_ctrl_next.settled = !align_ok;
            entry_lim_next          = {1'b0, addr_in} + (AW+1)'(access_bytes);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_ctrl_reg <= '0;
        end
        else
        begin
            entry_ctrl_reg <= entry_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_addr_reg <= addr_in;
            entry_lim_reg  <= entry_lim_next;
            item_kind_reg  <= region_kind;
            item_tag_reg   <= region_tag;
        end
    end

    assign ch_ctrl[0] = entry_ctrl_reg;
    assign ch_addr[0] = entry_addr_reg;
    assign ch_lim[0]  = entry_lim_reg;
    assign ch_tag[0]  = 8'd0;
    assign ch_off[0]  = 32'd0;
    assign ch_idx[0]  = '0;

    // row of slot cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        ard_cell #(
            .AW  (AW),
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctrl  (ch_ctrl[i]),
            .in_addr  (ch_addr[i]),
            .in_lim   (ch_lim[i]),
            .in_tag   (ch_tag[i]),
            .in_off   (ch_off[i]),
            .in_idx   (ch_idx[i]),
            .out_ctrl (ch_ctrl[i+1]),
            .out_addr (ch_addr[i+1]),
            .out_lim  (ch_lim[i+1]),
            .out_tag  (ch_tag[i+1]),
            .out_off  (ch_off[i+1]),
            .out_idx  (ch_idx[i+1]),
            .wr_en    (wr_en),
            .wr_idx   (ch_idx[N]),
            .wr_base  (ch_addr[N]),
            .wr_end   (ch_lim[N]),
            .wr_kind  (item_kind_reg),
            .wr_tag   (item_tag_reg)
        );
    end

    assign last = ch_ctrl[N];

    // commit a clean add into its free slot
    assign wr_en = last.active && last.add && !last.settled && !last.overlap && last.free_found;

    // result stage
    always_comb
    begin
        done_next   = last.active;
        status_next = ST_MISS;
        ftag_next   = 8'd0;
        fkind_next  = 1'b0;
        off_next    = 32'd0;
        if (last.add)
        begin
            if (last.settled)
            begin
                status_next = ST_ZERO;
            end
            else if (last.overlap)
            begin
                status_next = ST_OVERLAP;
            end
            else if (!last.free_found)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_ADDED;
            end
        end
        else if (last.settled)
        begin
            status_next = ST_MISALIGNED;
        end
        else if (last.hit)
        begin
            status_next = ST_HIT;
            ftag_next   = ch_tag[N];
            fkind_next  = last.hit_kind;
            off_next    = ch_off[N];
        end
    end

    // busy from transfer until the token leaves the chain
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (last.active)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last.active)
        begin
            status_reg <= status_next;
            ftag_reg   <= ftag_next;
            fkind_reg  <= fkind_next;
            off_reg    <= off_next;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign found_tag  = ftag_reg;
    assign found_kind = fkind_reg;
    assign offset     = off_reg;

    // a result is never shown while a command is still in the chain
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // an accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && entry_ctrl_reg.active)
        else $error("accepted command did not enter the chain");

    // the token at the chain entry belongs to a command in flight
    a_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        entry_ctrl_reg.active |-> busy_reg)
        else $error("token in chain while idle");

    // the slot written always lies inside the table
    a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (ch_idx[N] <= IW'(N - 1)))
        else $error("slot write outside the table");

    // non-hit results carry zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_HIT)) |->
            (ftag_reg == 8'd0) && !fkind_reg && (off_reg == 32'd0))
        else $error("non-hit result with nonzero fields");

endmodule

>>> rtl/ard_cell.sv
// one slot of the region table, checking the passing token against its region
`timescale 1ns / 1ps

module ard_cell
    import ard_pkg::*;
#(
    parameter int AW  = ADDRESS_BITS_DEF,
    parameter int IW  = 3,
    parameter int IDX = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    // token from the left neighbor
    input  tok_ctrl_t       in_ctrl,
    input  logic [AW-1:0]   in_addr,
    input  logic [AW:0]     in_lim,
    input  logic [7:0]      in_tag,
    input  logic [31:0]     in_off,
    input  logic [IW-1:0]   in_idx,
    // token to the right neighbor
    output tok_ctrl_t       out_ctrl,
    output logic [AW-1:0]   out_addr,
    output logic [AW:0]     out_lim,
    output logic [7:0]      out_tag,
    output logic [31:0]     out_off,
    output logic [IW-1:0]   out_idx,
    // slot write at the end of an accepted add
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_idx,
    input  logic [AW-1:0]   wr_base,
    input  logic [AW:0]     wr_end,
    input  logic            wr_kind,
    input  logic [7:0]      wr_tag
);

    logic            valid_reg;
    logic [AW-1:0]   base_reg;
    logic [AW:0]     end_reg;
    logic            kind_reg;
    logic [7:0]      tag_reg;

    tok_ctrl_t       ctrl_reg, ctrl_next;
    logic [AW-1:0]   addr_reg;
    logic [AW:0]     lim_reg;
    logic [7:0]      otag_reg, otag_next;
    logic [31:0]     off_reg, off_next;
    logic [IW-1:0]   idx_reg, idx_next;

    logic            sel;

    assign sel = wr_en && (wr_idx == IW'(IDX));

    // slot valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    // slot contents
    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            base_reg <= wr_base;
            end_reg  <= wr_end;
            kind_reg <= wr_kind;
            tag_reg  <= wr_tag;
        end
    end

    // compare the token against this slot
    always_comb
    begin
        ctrl_next = in_ctrl;
        otag_next = in_tag;
        off_next  = in_off;
        idx_next  = in_idx;
        if (in_ctrl.active && !in_ctrl.settled)
        begin
            if (in_ctrl.add)
            begin
                if (valid_reg && ({1'b0, in_addr} < end_reg) && ({1'b0, base_reg} < in_lim))
                begin
                    ctrl_next.overlap = 1'b1;
                end
                if (!valid_reg && !in_ctrl.free_found)
                begin
                    ctrl_next.free_found = 1'b1;
                    idx_next             = IW'(IDX);
                end
            end
            else if (valid_reg && !in_ctrl.hit && (in_addr >= base_reg) && (in_lim <= end_reg))
            begin
                ctrl_next.hit      = 1'b1;
                ctrl_next.hit_kind = kind_reg;
                otag_next          = tag_reg;
                off_next           = 32'(in_addr - base_reg);
            end
        end
    end

    // token control to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // token payload to the neighbor
    always_ff @(posedge clk)
    begin
        addr_reg <= in_addr;
        lim_reg  <= in_lim;
        otag_reg <= otag_next;
        off_reg  <= off_next;
        idx_reg  <= idx_next;
    end

    assign out_ctrl = ctrl_reg;
    assign out_addr = addr_reg;
    assign out_lim  = lim_reg;
    assign out_tag  = otag_reg;
    assign out_off  = off_reg;
    assign out_idx  = idx_reg;

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the address region decoder: directed and random command traffic
`timescale 1ns / 1ps

module tb_top;
    import ard_pkg::*;

    localparam int SLOTS       = REGION_SLOTS_DEF;
    localparam int LATENCY     = REGION_SLOTS_DEF + 1;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int MAX_REPORTS = 10;

    // one decoded result as the block should present it
    typedef struct packed {
        status_t     status;
        logic [7:0]  tag;
        logic        kind;
        logic [31:0] offset;
    } decode_result_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        command      = CMD_LOOKUP;
    logic [31:0] address      = '0;
    logic [3:0]  access_bytes = 4'd1;
    logic [31:0] region_size  = '0;
    logic        region_kind  = 1'b0;
    logic [7:0]  region_tag   = '0;
    logic        busy;
    logic        done;
    logic [2:0]  status;
    logic [7:0]  found_tag;
    logic        found_kind;
    logic [31:0] offset;

    // predicted region table
    logic        map_valid [SLOTS];
    logic [31:0] map_base  [SLOTS];
    logic [32:0] map_end   [SLOTS];
    logic        map_kind  [SLOTS];
    logic [7:0]  map_tag   [SLOTS];

    decode_result_t pending_decodes[$];
    int             mismatch_count = 0;
    int             checked_count  = 0;
    int             cycle_count    = 0;
    int             idle_pct       = 0;
    int             status_count [7];

    address_region_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .address      (address),
        .access_bytes (access_bytes),
        .region_size  (region_size),
        .region_kind  (region_kind),
        .region_tag   (region_tag),
        .done         (done),
        .status       (status),
        .found_tag    (found_tag),
        .found_kind   (found_kind),
        .offset       (offset)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("address_region_decoder verification failed");
            $finish;
        end
    end

    // work out the result of one command and update the predicted table
    function automatic decode_result_t decode_region_command(
        input logic        cmd,
        input logic [31:0] addr,
        input logic [3:0]  nbytes,
        input logic [31:0] size,
        input logic        kind,
        input logic [7:0]  tag
    );
        decode_result_t r;
        logic [32:0]    top;
        int             free_idx;
        logic           clash;
        int             i;
        r          = '0;
        r.status   = ST_MISS;
        free_idx   = -1;
        clash      = 1'b0;
        top        = {1'b0, addr} + {1'b0, size};
        if (cmd == CMD_ADD)
        begin
            if (size == 32'd0)
                r.status = ST_ZERO;
            else
            begin
                // overlap takes precedence over a full table
                for (i = 0; i < SLOTS; i++)
                begin
                    if (map_valid[i])
                    begin
                        if ({1'b0, addr} < map_end[i] && {1'b0, map_base[i]} < top)
                            clash = 1'b1;
                    end
                    else if (free_idx < 0)
                        free_idx = i;
                end
                if (clash)
                    r.status = ST_OVERLAP;
                else if (free_idx < 0)
                    r.status = ST_FULL;
                else
                begin
                    map_valid[free_idx] = 1'b1;
                    map_base[free_idx]  = addr;
                    map_end[free_idx]   = top;
                    map_kind[free_idx]  = kind;
                    map_tag[free_idx]   = tag;
                    r.status            = ST_ADDED;
                end
            end
        end
        else if (!(nbytes == 4'd1 || nbytes == 4'd2 || nbytes == 4'd4 || nbytes == 4'd8)
                 || (addr & ({28'd0, nbytes} - 32'd1)) != 32'd0)
            r.status = ST_MISALIGNED;
        else
        begin
            // lowest slot that holds every byte of the access
            for (i = SLOTS - 1; i >= 0; i--)
            begin
                if (map_valid[i] && addr >= map_base[i]
                    && {1'b0, addr} + {29'd0, nbytes} <= map_end[i])
                begin
                    r.status = ST_HIT;
                    r.tag    = map_tag[i];
                    r.kind   = map_kind[i];
                    r.offset = addr - map_base[i];
                end
            end
        end
        return r;
    endfunction

    // one command transfer, with random idle cycles in front of it
    task automatic send_transfer(
        input logic        cmd,
        input logic [31:0] addr,
        input logic [3:0]  nbytes,
        input logic [31:0] size,
        input logic        kind,
        input logic [7:0]  tag
    );
        decode_result_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        address      <= addr;
        access_bytes <= nbytes;
        region_size  <= size;
        region_kind  <= kind;
        region_tag   <= tag;
        do
            @(posedge clk);
        while (busy);
        r = decode_region_command(cmd, addr, nbytes, size, kind, tag);
        status_count[r.status]++;
        pending_decodes.push_back(r);
    endtask

    // lookup with random content in the fields it does not use
    task automatic send_lookup(input logic [31:0] addr, input logic [3:0] nbytes);
        send_transfer(CMD_LOOKUP, addr, nbytes, $urandom, 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
    endtask

    task automatic send_add(
        input logic [31:0] base,
        input logic [31:0] size,
        input logic        kind,
        input logic [7:0]  tag
    );
        send_transfer(CMD_ADD, base, 4'($urandom_range(0, 15)), size, kind, tag);
    endtask

    // result checker: every done strobe is one transfer out of the block
    always @(posedge clk)
    begin
        decode_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_decodes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d tag %h kind %b offset %h",
                             status, found_tag, found_kind, offset);
            end
            else
            begin
                exp_r = pending_decodes.pop_front();
                checked_count++;
                if (status !== exp_r.status || found_tag !== exp_r.tag
                    || found_kind !== exp_r.kind || offset !== exp_r.offset)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch on result %0d: expected status %0d tag %h kind %b offset %h",
                                 checked_count, exp_r.status, exp_r.tag, exp_r.kind,
                                 exp_r.offset);
                        $display("    got status %0d tag %h kind %b offset %h",
                                 status, found_tag, found_kind, offset);
                    end
                end
            end
        end
    end

    // lookup into an empty table
    task automatic test_empty_table;
        send_lookup(32'h0000_0000, 4'd1);
    endtask

    // region insertion: edges of the address space, zero size, overlap, adjacency
    task automatic test_add_rules;
        send_add(32'h0000_0000, 32'h0000_1000, 1'b0, 8'h5A);
        send_add(32'hFFFF_F000, 32'h0000_1000, 1'b1, 8'hFF);
        send_add(32'h0000_1000, 32'h0000_0000, 1'b1, 8'h11);
        send_add(32'h0000_0FF8, 32'h0000_0010, 1'b0, 8'h22);
        send_add(32'h0000_1000, 32'h0000_0100, 1'b1, 8'h01);
        send_add(32'h0000_2000, 32'h0000_0006, 1'b0, 8'h80);
    endtask

    // lookups: hits at region edges, straddles, misses and bad access sizes
    task automatic test_lookup_rules;
        send_lookup(32'hFFFF_FFF8, 4'd8);
        send_lookup(32'hFFFF_FFFF, 4'd1);
        send_lookup(32'h0000_0000, 4'd1);
        send_lookup(32'h0000_0FF8, 4'd8);
        send_lookup(32'h0000_0FFC, 4'd8);
        send_lookup(32'h0000_10F8, 4'd8);
        send_lookup(32'h0000_1100, 4'd1);
        send_lookup(32'h0000_2004, 4'd4);
        send_lookup(32'h0000_2004, 4'd2);
        send_lookup(32'h0000_0000, 4'd0);
        send_lookup(32'h0000_0000, 4'd3);
        send_lookup(32'h0000_0000, 4'd15);
        send_lookup(32'h0000_0001, 4'd2);
    endtask

    // fill the remaining slots, then a full table and overlap ahead of full
    task automatic test_table_full;
        send_add(32'h8000_0000, 32'h1000_0000, 1'b1, 8'hA5);
        send_add(32'h4000_0000, 32'h0001_0000, 1'b0, 8'h3C);
        send_add(32'h0010_0000, 32'h0000_0100, 1'b1, 8'h81);
        send_add(32'hC000_0000, 32'h2000_0003, 1'b0, 8'h7E);
        send_add(32'h0000_3000, 32'h0000_0010, 1'b1, 8'h42);
        send_add(32'h8000_0010, 32'h0000_0004, 1'b0, 8'h24);
    endtask

    // random traffic, mostly lookups aimed at and around stored regions
    task automatic test_random_traffic(input int pct, input int count);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] a;
        logic [3:0]  n;
        logic [31:0] size;
        int          idx;
        int          k;
        idle_pct = pct;
        for (k = 0; k < count; k++)
        begin
            idx = $urandom_range(0, SLOTS - 1);
            lo  = {32'd0, map_base[idx]};
            hi  = {31'd0, map_end[idx]};
            if (!map_valid[idx])
            begin
                lo = {32'd0, $urandom};
                hi = lo + 64'd64;
            end
            if ($urandom_range(0, 99) < 20)
            begin
                // add: almost always refused once the table is full
                case ($urandom_range(0, 3))
                    0:       size = 32'd0;
                    1, 2:    size = $urandom_range(1, 256);
                    default: size = $urandom;
                endcase
                if ($urandom_range(0, 1) == 0)
                    a = {32'd0, $urandom};
                else
                    a = hi - $urandom_range(0, 8);
                send_add(a[31:0], size, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            end
            else
            begin
                n = 4'd1 << $urandom_range(0, 3);
                case ($urandom_range(0, 4))
                    0:       a = lo + ($urandom % (hi - lo));
                    1:       a = hi - $urandom_range(0, 16);
                    2:       a = lo - $urandom_range(0, 16);
                    3:       a = lo + $urandom_range(0, 16);
                    default: a = {32'd0, $urandom};
                endcase
                // a few unaligned addresses and illegal sizes
                if ($urandom_range(0, 7) != 0)
                    a = a & ~({60'd0, n} - 64'd1);
                if ($urandom_range(0, 9) == 0)
                    n = 4'($urandom_range(0, 15));
                send_lookup(a[31:0], n);
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        for (int s = 0; s < 7; s++)
            status_count[s] = 0;
        for (int s = 0; s < SLOTS; s++)
            map_valid[s] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_add_rules();
        test_lookup_rules();
        test_table_full();
        test_random_traffic(33, 450);
        test_random_traffic(55, 450);
        test_random_traffic(0, 450);

        // drain the remaining results, then allow for stray strobes
        start <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);

        $display("covered %0d results: %0d hits, %0d misses, %0d misaligned lookups",
                 checked_count, status_count[ST_HIT], status_count[ST_MISS],
                 status_count[ST_MISALIGNED]);
        $display("adds: %0d stored, %0d zero size, %0d overlapping, %0d refused on full table",
                 status_count[ST_ADDED], status_count[ST_ZERO], status_count[ST_OVERLAP],
                 status_count[ST_FULL]);
        if (mismatch_count == 0 && pending_decodes.size() == 0)
            $display("address_region_decoder verification clean");
        else
            $display("address_region_decoder verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ard_pkg.sv
rtl/ard_cell.sv
rtl/address_region_decoder.sv
sim/tb_top.sv
